FILE: design/gtsd_pkg.sv
// ----------------------------------------------------------------------------
// gtsd_pkg
// Shared types, constants and helpers for the GPS time sync / drift block.
// ----------------------------------------------------------------------------
`default_nettype none

package gtsd_pkg;

    // Width of the running time arithmetic (date seconds, base, difference).
    localparam int TIME_WIDTH = 32;

    // Calendar constants
    localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
    localparam logic [9:0]  LEAPS_1969    = 10'd477;   // y/4 - y/100 + y/400 at 1969
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
    localparam logic [6:0]  YEARS_PER_CENT = 7'd100;

    // Drift scaling: ms per day, Q.8 output
    localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
    localparam int          DRIFT_FRAC  = 8;

    // Reciprocal constants for division by 100 (12-bit input) and 1000 (32-bit input)
    localparam logic [12:0] RECIP_100        = 13'd5243;
    localparam int          RECIP_100_SHIFT  = 19;
    localparam logic [28:0] RECIP_1000       = 29'h10624DD3;
    localparam int          RECIP_1000_SHIFT = 38;

    // Bit-serial divider geometry: 33 quotient bits, numerator split hi/lo
    localparam int DIV_STEPS = 33;
    localparam int DIV_HI_W  = 34;
    localparam int DIV_CNT_W = 6;

    // Saturation bounds of the Q23.8 drift and the 32-bit error
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAG = 32'h8000_0000;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [31:0]        epoch_seconds;
        logic signed [31:0] sync_error;
        logic signed [31:0] drift_per_day;
        logic               first_sync;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAL,
        S_DAYS,
        S_SECS,
        S_ELAP,
        S_ERR,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_HI_W-1:0]  num_hi;
        logic [DIV_STEPS-1:0] num_lo;
        logic [31:0]          den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic                 ovf;
        logic [DIV_STEPS-1:0] quo;
    } div_rsp_t;

    // floor(y / 100) for a 12-bit year, exact over the full 12-bit range
    function automatic logic [5:0] div100(input logic [11:0] y);
        logic [24:0] p;
        p = 25'(y) * 25'(RECIP_100);
        return p[RECIP_100_SHIFT +: 6];
    endfunction

    // Days in the months before the given one; codes past December count the year
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd0:  d = 9'd0;
            4'd1:  d = 9'd0;
            4'd2:  d = 9'd31;
            4'd3:  d = 9'd59;
            4'd4:  d = 9'd90;
            4'd5:  d = 9'd120;
            4'd6:  d = 9'd151;
            4'd7:  d = 9'd181;
            4'd8:  d = 9'd212;
            4'd9:  d = 9'd243;
            4'd10: d = 9'd273;
            4'd11: d = 9'd304;
            4'd12: d = 9'd334;
            4'd13: d = 9'd365;
            4'd14: d = 9'd365;
            4'd15: d = 9'd365;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: design/gtsd_div.sv
// ----------------------------------------------------------------------------
// gtsd_div
// Bit-serial restoring divider, one quotient bit per cycle, overflow flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module gtsd_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  gtsd_pkg::div_req_t req,
    output gtsd_pkg::div_rsp_t rsp
);
    import gtsd_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 ovf_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [31:0]          rem_reg;
    logic [DIV_STEPS-1:0] sh_reg;   // numerator bits out the top, quotient bits in the bottom
    logic [31:0]          den_reg;

    logic [32:0] trial;
    logic [32:0] trial_sub;
    logic        ge;

    assign trial     = {rem_reg, sh_reg[DIV_STEPS-1]};
    assign ge        = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.num_hi[31:0];
            sh_reg  <= req.num_lo;
            den_reg <= req.den;
            // quotient would not fit in DIV_STEPS bits
            ovf_reg <= req.num_hi >= DIV_HI_W'(req.den);
        end else if (busy_reg) begin
            rem_reg <= ge ? trial_sub[31:0] : trial[31:0];
            sh_reg  <= {sh_reg[DIV_STEPS-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quo  = sh_reg;

endmodule

`default_nettype wire

FILE: design/gps_time_sync_drift.sv
// ----------------------------------------------------------------------------
// gps_time_sync_drift: GPS date to epoch seconds, clock error and drift per day
// One beat in flight: a new beat is taken only after the last one has left the
// OUT step, which waits while a full output register cannot drain. The base beat
// and beats with zero elapsed time skip the drift path; all others also run the
// 33-step bit-serial divider. Synchronous active-low reset clears the sync
// state, error and drift to zero and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_time_sync_drift (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gtsd_pkg::item_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output gtsd_pkg::result_t m_data
);
    import gtsd_pkg::*;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;

    logic s_accept;
    logic out_free;
    logic div_start;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // Working registers for the beat in flight
    item_t                 in_reg;
    logic [5:0]            yq1_reg;     // (year-1)/100
    logic [5:0]            yq_reg;      // year/100
    logic [16:0]           hms_reg;     // hour/min/sec in seconds
    logic [TIME_WIDTH-1:0] days_reg;
    logic [TIME_WIDTH-1:0] gps_reg;
    logic [31:0]           elapsed_reg;
    logic [22:0]           esec_reg;    // elapsed / 1000
    logic                  neg_reg;
    logic [31:0]           mag_reg;
    logic [58:0]           prod_reg;    // |error| * ms per day
    logic                  first_reg;

    // Sync state
    logic                  synced_reg;
    logic [31:0]           base_ms_reg;
    logic [TIME_WIDTH-1:0] base_sec_reg;
    logic [31:0]           last_error_reg;
    logic [31:0]           last_drift_reg;

    // Output register
    logic    m_valid_reg;
    result_t m_data_reg;

    // Input is taken only between beats; a finished result may still sit in
    // the output register, it is the OUT step that waits for room.
    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_CAL;
                end
            end
            S_CAL:  state_next = S_DAYS;
            S_DAYS: state_next = S_SECS;
            S_SECS: state_next = S_ELAP;
            S_ELAP: state_next = S_ERR;
            S_ERR: begin
                // base beat and zero elapsed time have no drift to work out
                if (!synced_reg || elapsed_reg == '0) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MUL: state_next = S_DSTART;
            S_DSTART: begin
                div_start  = 1'b1;
                state_next = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_rsp.done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Calendar: year quotients and time of day
    // ------------------------------------------------------------------
    logic [11:0] year_m1;
    logic [16:0] hms_next;

    assign year_m1  = in_reg.year - 12'd1;
    assign hms_next = 17'(in_reg.hour) * 17'(SEC_PER_HOUR)
                    + 17'(in_reg.minute) * 17'(SEC_PER_MIN)
                    + 17'(in_reg.second);

    // ------------------------------------------------------------------
    // Day count: whole years past 1970, months, day of month
    // ------------------------------------------------------------------
    logic                  year_past;
    logic [11:0]           year_off;
    logic [TIME_WIDTH-1:0] leaps;
    logic [TIME_WIDTH-1:0] days_years;
    logic                  cent_year;
    logic                  is_leap;
    logic                  leap_add;
    logic [TIME_WIDTH-1:0] days_next;

    assign year_past  = in_reg.year > EPOCH_YEAR;
    assign year_off   = in_reg.year - EPOCH_YEAR;
    assign leaps      = TIME_WIDTH'(year_m1[11:2]) - TIME_WIDTH'(yq1_reg)
                      + TIME_WIDTH'(yq1_reg[5:2]);
    assign days_years = year_past
                      ? TIME_WIDTH'(year_off) * TIME_WIDTH'(DAYS_PER_YEAR) + leaps
                        - TIME_WIDTH'(LEAPS_1969)
                      : '0;
    // Gregorian rule: every 4th year, centuries only when divisible by 400
    assign cent_year  = in_reg.year == 12'(12'(yq_reg) * 12'(YEARS_PER_CENT));
    assign is_leap    = (in_reg.year[1:0] == 2'd0) && (!cent_year || yq_reg[1:0] == 2'd0);
    // Feb 29 counts once February lies behind us (codes past December included)
    assign leap_add   = is_leap && (in_reg.month > 4'd2);
    // day 0 falls one day before the 1st and can wrap below the epoch
    assign days_next  = days_years + TIME_WIDTH'(cum_days(in_reg.month))
                      + TIME_WIDTH'(leap_add) + TIME_WIDTH'(in_reg.day) - TIME_WIDTH'(1);

    // ------------------------------------------------------------------
    // Seconds, elapsed time, error
    // ------------------------------------------------------------------
    logic [TIME_WIDTH-1:0] gps_next;
    logic [60:0]           esec_prod;
    logic [TIME_WIDTH-1:0] internal_sec;
    logic [TIME_WIDTH-1:0] diff;
    logic                  diff_neg;
    logic [TIME_WIDTH-1:0] diff_mag;
    logic [31:0]           mag_sat;
    logic [31:0]           error_next;

    assign gps_next     = TIME_WIDTH'(days_reg * TIME_WIDTH'(SEC_PER_DAY))
                        + TIME_WIDTH'(hms_reg);
    // exact floor(x/1000) for any 32-bit x
    assign esec_prod    = 61'(elapsed_reg) * 61'(RECIP_1000);
    assign internal_sec = base_sec_reg + TIME_WIDTH'(esec_reg);
    assign diff         = gps_reg - internal_sec;
    assign diff_neg     = diff[TIME_WIDTH-1];
    assign diff_mag     = diff_neg ? (~diff + TIME_WIDTH'(1)) : diff;

    always_comb begin
        if (!diff_neg && diff_mag > TIME_WIDTH'(POS_MAX)) begin
            mag_sat = POS_MAX;
        end else if (diff_neg && diff_mag > TIME_WIDTH'(NEG_MAG)) begin
            mag_sat = NEG_MAG;
        end else begin
            mag_sat = diff_mag[31:0];
        end
    end

    assign error_next = diff_neg ? (32'd0 - mag_sat) : mag_sat;

    // ------------------------------------------------------------------
    // Drift: |error| * 86400000 * 256 / elapsed through the serial divider.
    // The divider returns 33 quotient bits and flags anything larger.
    // ------------------------------------------------------------------
    logic [66:0] drift_num;
    logic [31:0] drift_mag;
    logic [31:0] drift_next;

    assign drift_num      = {prod_reg, DRIFT_FRAC'(0)};
    assign div_req.start  = div_start;
    assign div_req.num_hi = drift_num[66:DIV_STEPS];
    assign div_req.num_lo = drift_num[DIV_STEPS-1:0];
    assign div_req.den    = elapsed_reg;

    gtsd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        if (!neg_reg) begin
            if (div_rsp.ovf || div_rsp.quo > DIV_STEPS'(POS_MAX)) begin
                drift_mag = POS_MAX;
            end else begin
                drift_mag = div_rsp.quo[31:0];
            end
        end else begin
            if (div_rsp.ovf || div_rsp.quo > DIV_STEPS'(NEG_MAG)) begin
                drift_mag = NEG_MAG;
            end else begin
                drift_mag = div_rsp.quo[31:0];
            end
        end
    end

    assign drift_next = neg_reg ? (32'd0 - drift_mag) : drift_mag;

    // ------------------------------------------------------------------
    // Working registers (payload, no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= s_data;
        end
        if (state_reg == S_CAL) begin
            yq1_reg <= div100(year_m1);
            yq_reg  <= div100(in_reg.year);
            hms_reg <= hms_next;
        end
        if (state_reg == S_DAYS) begin
            days_reg <= days_next;
        end
        if (state_reg == S_SECS) begin
            gps_reg     <= gps_next;
            elapsed_reg <= in_reg.now_ms - base_ms_reg;
        end
        if (state_reg == S_ELAP) begin
            esec_reg <= esec_prod[RECIP_1000_SHIFT +: 23];
        end
        if (state_reg == S_ERR) begin
            neg_reg   <= diff_neg;
            mag_reg   <= mag_sat;
            first_reg <= !synced_reg;
        end
        if (state_reg == S_MUL) begin
            prod_reg <= 59'(mag_reg) * 59'(MS_PER_DAY);
        end
    end

    // ------------------------------------------------------------------
    // Sync state: base on the first beat, error and drift after that
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            synced_reg     <= 1'b0;
            base_ms_reg    <= '0;
            base_sec_reg   <= '0;
            last_error_reg <= '0;
            last_drift_reg <= '0;
        end else begin
            if (state_reg == S_ERR) begin
                if (!synced_reg) begin
                    synced_reg   <= 1'b1;
                    base_ms_reg  <= in_reg.now_ms;
                    base_sec_reg <= gps_reg;
                end else begin
                    last_error_reg <= error_next;
                end
            end
            if (state_reg == S_DWAIT && div_rsp.done) begin
                last_drift_reg <= drift_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            m_data_reg.epoch_seconds <= gps_reg[31:0];
            m_data_reg.sync_error    <= last_error_reg;
            m_data_reg.drift_per_day <= last_drift_reg;
            m_data_reg.first_sync    <= first_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // one beat at a time: no second accept right after the first
    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("input accepted while a beat is in flight");

    // divider only runs for a synced beat with nonzero elapsed time
    a_div_guard: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DWAIT) |-> (synced_reg && elapsed_reg != '0))
        else $error("drift division without base or with zero elapsed time");

    // divider completion is only seen while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DWAIT))
        else $error("divider finished outside the wait step");
`endif

endmodule

`default_nettype wire
